// ===== design/gspe_pkg.sv =====
`timescale 1ns / 1ps

package gspe_pkg;

  // Field and datapath widths
  localparam int POS_W   = 16;
  localparam int COEF_W  = 32;
  localparam int GAIN_W  = 16;
  localparam int COLOR_W = 64;
  localparam int CH_W    = 16;
  localparam int CFG_IDX_W = 8;

  // Quadratic form: Q.32 sums, clamped q
  localparam int SUM_W = 54;
  localparam int Q_W   = 40;
  localparam logic signed [SUM_W-1:0] Q_MAX = 54'sd274877906944;   // +64.0 in Q.32
  localparam logic signed [SUM_W-1:0] Q_MIN = -54'sd274877906944;  // -64.0 in Q.32

  // Exponent path
  localparam int MUL_W = 57;
  localparam int U_W   = 41;
  localparam int N_W   = 9;
  localparam int FRAC_W = 32;
  localparam logic signed [17:0] HALF_LOG2E = 18'sd47274;  // log2(e)/2 in Q0.16
  localparam int ROM_W = 33;
  localparam int P_W   = 49;
  localparam int SH_W  = 10;
  localparam int W_W   = 17;
  localparam logic [W_W-1:0] W_ONE = 17'd65536;

  localparam int EXP_TABLE_DEPTH_DEF = 64;

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_GAIN  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RGBA = 8'd7;

  localparam logic [GAIN_W-1:0] PEAK_GAIN_RST = 16'd16384;

  typedef struct packed {
    logic signed [COEF_W-1:0] xx;
    logic signed [COEF_W-1:0] xy;
    logic signed [COEF_W-1:0] yy;
    logic signed [COEF_W-1:0] x;
    logic signed [COEF_W-1:0] y;
    logic signed [COEF_W-1:0] cst;
  } coef_t;

  // e^-y for y in Q.32 by the truncated series sum (-y)^k/k!, k = 0..24.
  // Used only to build the constant exponent table.
  function automatic logic [ROM_W-1:0] exp_neg_q32(input logic [63:0] y);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    term = ONE_Q32;
    pos  = ONE_Q32;
    neg  = 64'd0;
    term = ((term * y) >> 32) / 64'd1;  neg = neg + term;
    term = ((term * y) >> 32) / 64'd2;  pos = pos + term;
    term = ((term * y) >> 32) / 64'd3;  neg = neg + term;
    term = ((term * y) >> 32) / 64'd4;  pos = pos + term;
    term = ((term * y) >> 32) / 64'd5;  neg = neg + term;
    term = ((term * y) >> 32) / 64'd6;  pos = pos + term;
    term = ((term * y) >> 32) / 64'd7;  neg = neg + term;
    term = ((term * y) >> 32) / 64'd8;  pos = pos + term;
    term = ((term * y) >> 32) / 64'd9;  neg = neg + term;
    term = ((term * y) >> 32) / 64'd10; pos = pos + term;
    term = ((term * y) >> 32) / 64'd11; neg = neg + term;
    term = ((term * y) >> 32) / 64'd12; pos = pos + term;
    term = ((term * y) >> 32) / 64'd13; neg = neg + term;
    term = ((term * y) >> 32) / 64'd14; pos = pos + term;
    term = ((term * y) >> 32) / 64'd15; neg = neg + term;
    term = ((term * y) >> 32) / 64'd16; pos = pos + term;
    term = ((term * y) >> 32) / 64'd17; neg = neg + term;
    term = ((term * y) >> 32) / 64'd18; pos = pos + term;
    term = ((term * y) >> 32) / 64'd19; neg = neg + term;
    term = ((term * y) >> 32) / 64'd20; pos = pos + term;
    term = ((term * y) >> 32) / 64'd21; neg = neg + term;
    term = ((term * y) >> 32) / 64'd22; pos = pos + term;
    term = ((term * y) >> 32) / 64'd23; neg = neg + term;
    term = ((term * y) >> 32) / 64'd24; pos = pos + term;
    r = (pos > neg) ? (pos - neg) : 64'd0;
    if (r > ONE_Q32) begin
      r = ONE_Q32;
    end
    return r[ROM_W-1:0];
  endfunction

endpackage

// ===== design/gspe_quad.sv =====
`timescale 1ns / 1ps

// Quadratic form q = p'Mp in Q.32, four stages:
// squares, coefficient products, pair sums, final sum and clamp.
module gspe_quad (
  input  logic                          clk,
  input  logic                          rst,
  input  gspe_pkg::coef_t               coef,
  input  logic                          pos_valid,
  output logic                          pos_ready,
  input  logic signed [gspe_pkg::POS_W-1:0] pos_x,
  input  logic signed [gspe_pkg::POS_W-1:0] pos_y,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic signed [gspe_pkg::Q_W-1:0]   q
);
  import gspe_pkg::*;

  localparam int NST = 4;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  // stage 1
  logic signed [2*POS_W-1:0] sq_xx, sq_xy, sq_yy;
  logic signed [POS_W-1:0]   x1, y1;
  // stage 2
  logic signed [63:0]            t_xx, t_xy, t_yy;
  logic signed [COEF_W+POS_W-1:0] t_x, t_y;
  // stage 3
  logic signed [SUM_W-1:0] sum_a, sum_b, sum_c;
  // stage 4 input
  logic signed [SUM_W-1:0] sum_all;

  // per-stage advance: a stage loads when empty or when its successor moves
  always_comb begin
    en[NST-1] = !vld[NST-1] || q_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign pos_ready = en[0];
  assign q_valid   = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pos_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: products of the coordinates
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_xx <= pos_x * pos_x;
      sq_xy <= pos_x * pos_y;
      sq_yy <= pos_y * pos_y;
      x1    <= pos_x;
      y1    <= pos_y;
    end
  end

  // stage 2: one coefficient multiply per term
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_xx <= coef.xx * sq_xx;
      t_xy <= coef.xy * sq_xy;
      t_yy <= coef.yy * sq_yy;
      t_x  <= coef.x * x1;
      t_y  <= coef.y * y1;
    end
  end

  // stage 3: align to Q.32 (floor on the quadratic terms), add in pairs
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum_a <= SUM_W'(t_xx >>> 12) + SUM_W'(t_xy >>> 12);
      sum_b <= SUM_W'(t_yy >>> 12) + (SUM_W'(t_x) <<< 2);
      sum_c <= (SUM_W'(t_y) <<< 2) + (SUM_W'(coef.cst) <<< 16);
    end
  end

  // stage 4: total and clamp to [-64, +64]
  assign sum_all = sum_a + sum_b + sum_c;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (sum_all > Q_MAX) begin
        q <= Q_W'(Q_MAX);
      end else if (sum_all < Q_MIN) begin
        q <= Q_W'(Q_MIN);
      end else begin
        q <= Q_W'(sum_all);
      end
    end
  end

endmodule

// ===== design/gspe_weight.sv =====
`timescale 1ns / 1ps

// Weight w = gain * 2^-(q*log2(e)/2), saturated to [0, 1] in Q.16.
// Five stages: scale, split, table, gain multiply, shift and saturate.
module gspe_weight #(
  parameter int EXP_TABLE_DEPTH = gspe_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [gspe_pkg::GAIN_W-1:0]      peak_gain,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  logic signed [gspe_pkg::Q_W-1:0]  q,
  output logic                             w_valid,
  input  logic                             w_ready,
  output logic [gspe_pkg::W_W-1:0]         w
);
  import gspe_pkg::*;

  localparam int NST   = 5;
  localparam int IDX_W = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
  localparam int IP_W  = FRAC_W + IDX_W;
  localparam int SHA_W = $clog2(P_W);

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  // 2^(-i/D) in Q.32
  logic [ROM_W-1:0] rom [EXP_TABLE_DEPTH];

  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] Y = (64'(i) * LN2_Q32) / EXP_TABLE_DEPTH;
    assign rom[i] = exp_neg_q32(Y);
  end

  logic signed [MUL_W-1:0] u_prod;
  logic signed [U_W-1:0]   u;
  logic [IP_W-1:0]         idx_prod;
  logic signed [N_W-1:0]   n6, n7, n8;
  logic [IDX_W-1:0]        idx;
  logic [ROM_W-1:0]        rom_val;
  logic [P_W-1:0]          p;
  logic signed [SH_W-1:0]  sh;
  logic [P_W-1:0]          p_sh;
  logic [W_W-1:0]          w_next;

  always_comb begin
    en[NST-1] = !vld[NST-1] || w_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign q_ready = en[0];
  assign w_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= q_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: u = floor(q * log2(e)/2) in Q.32, constant multiplier
  assign u_prod = q * HALF_LOG2E;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u <= U_W'(u_prod >>> 16);
    end
  end

  // stage 2: integer part and table index from the fraction
  assign idx_prod = IP_W'(u[FRAC_W-1:0]) * IP_W'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n6  <= u[U_W-1:FRAC_W];
      idx <= idx_prod[IP_W-1:FRAC_W];
    end
  end

  // stage 3: table read
  always_ff @(posedge clk) begin
    if (en[2]) begin
      rom_val <= rom[idx];
      n7      <= n6;
    end
  end

  // stage 4: gain times fractional power, Q.46
  always_ff @(posedge clk) begin
    if (en[3]) begin
      p  <= peak_gain * rom_val;
      n8 <= n7;
    end
  end

  // stage 5: shift down by 30 + n and saturate to 1.0
  assign sh   = SH_W'(n8) + SH_W'(30);
  assign p_sh = p >> sh[SHA_W-1:0];

  always_comb begin
    if (p == '0) begin
      w_next = '0;
    end else if (sh < 0) begin
      w_next = W_ONE;
    end else if (sh >= SH_W'(P_W)) begin
      w_next = '0;
    end else if (p_sh > P_W'(W_ONE)) begin
      w_next = W_ONE;
    end else begin
      w_next = p_sh[W_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      w <= w_next;
    end
  end

endmodule

// ===== design/gaussian_splat_pixel_eval_core.sv =====
`timescale 1ns / 1ps

// Throughput: one pixel per cycle while results are taken; every stage holds its
// own valid bit and advances when empty or when the next stage moves, so
// bubbles close under stall. Path: quadratic-form, weight and output stages.
// Reset: clears all valid bits, coefficients and color to 0, peak_gain to 1.0.
// The exponent table is constant logic and needs no fill after reset.
module gaussian_splat_pixel_eval_core #(
  parameter int EXP_TABLE_DEPTH = gspe_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gspe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gspe_pkg::COLOR_W-1:0]         cfg_data,
  // pixel beats
  input  logic                                 pix_valid,
  output logic                                 pix_ready,
  input  logic signed [gspe_pkg::POS_W-1:0]    pos_x,
  input  logic signed [gspe_pkg::POS_W-1:0]    pos_y,
  // result beats
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [gspe_pkg::CH_W-1:0]            out_red,
  output logic [gspe_pkg::CH_W-1:0]            out_green,
  output logic [gspe_pkg::CH_W-1:0]            out_blue,
  output logic [gspe_pkg::CH_W-1:0]            out_alpha
);
  import gspe_pkg::*;

  coef_t              coef;
  logic [GAIN_W-1:0]  peak_gain;
  logic [COLOR_W-1:0] color_rgba;

  logic                  q_valid, q_ready;
  logic signed [Q_W-1:0] q;
  logic                  w_valid, w_ready;
  logic [W_W-1:0]        w;

  logic                   out_en;
  logic [CH_W+W_W-1:0]    prod_r, prod_g, prod_b, prod_a;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef       <= '0;
      peak_gain  <= PEAK_GAIN_RST;
      color_rgba <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COEF_XX:    coef.xx    <= cfg_data[COEF_W-1:0];
        REG_COEF_XY:    coef.xy    <= cfg_data[COEF_W-1:0];
        REG_COEF_YY:    coef.yy    <= cfg_data[COEF_W-1:0];
        REG_COEF_X:     coef.x     <= cfg_data[COEF_W-1:0];
        REG_COEF_Y:     coef.y     <= cfg_data[COEF_W-1:0];
        REG_COEF_CONST: coef.cst   <= cfg_data[COEF_W-1:0];
        REG_PEAK_GAIN:  peak_gain  <= cfg_data[GAIN_W-1:0];
        REG_COLOR_RGBA: color_rgba <= cfg_data;
        default: ;
      endcase
    end
  end

  gspe_quad u_quad (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .pos_valid (pix_valid),
    .pos_ready (pix_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q         (q)
  );

  gspe_weight #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_weight (
    .clk       (clk),
    .rst       (rst),
    .peak_gain (peak_gain),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q         (q),
    .w_valid   (w_valid),
    .w_ready   (w_ready),
    .w         (w)
  );

  // output stage: scale each channel by the weight
  assign out_en  = !res_valid || res_ready;
  assign w_ready = out_en;

  assign prod_r = color_rgba[63:48] * w;
  assign prod_g = color_rgba[47:32] * w;
  assign prod_b = color_rgba[31:16] * w;
  assign prod_a = color_rgba[15:0]  * w;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_en) begin
      res_valid <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_red   <= prod_r[2*CH_W-1:CH_W];
      out_green <= prod_g[2*CH_W-1:CH_W];
      out_blue  <= prod_b[2*CH_W-1:CH_W];
      out_alpha <= prod_a[2*CH_W-1:CH_W];
    end
  end

endmodule
